// ===== src/lcd4_pkg.sv =====
// ---------------------------------------------------------------------------
// lcd4_pkg
// Shared types and constants of the 4-bit character LCD command sequencer:
// request codes, queued job format and the fixed power-up nibble table.
// ---------------------------------------------------------------------------
package lcd4_pkg;

    typedef enum logic [3:0] {
        CMD_INIT       = 4'd0,
        CMD_DATA       = 4'd1,
        CMD_RAW        = 4'd2,
        CMD_CLEAR      = 4'd3,
        CMD_HOME       = 4'd4,
        CMD_SET_CURSOR = 4'd5,
        CMD_DISPLAY    = 4'd6,
        CMD_CURSOR     = 4'd7,
        CMD_BLINK      = 4'd8,
        CMD_SCROLL     = 4'd9,
        CMD_DIRECTION  = 4'd10,
        CMD_AUTOSCROLL = 4'd11,
        CMD_GLYPH_ADDR = 4'd12
    } cmd_t;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_COLUMNS    = 4'd0,
        CFG_LINE_COUNT = 4'd1
    } cfg_index_t;

    localparam logic [5:0] COLUMNS_RESET    = 6'd16;
    localparam logic [2:0] LINE_COUNT_RESET = 3'd2;

    // instruction opcodes
    localparam logic [7:0] OP_CLEAR      = 8'h01;
    localparam logic [7:0] OP_HOME       = 8'h02;
    localparam logic [7:0] OP_ENTRY      = 8'h04;
    localparam logic [7:0] OP_CONTROL    = 8'h08;
    localparam logic [7:0] OP_SHIFT_L    = 8'h18;
    localparam logic [7:0] OP_SHIFT_R    = 8'h1C;
    localparam logic [7:0] OP_GLYPH_ADDR = 8'h40;
    localparam logic [7:0] OP_DDRAM_ADDR = 8'h80;
    localparam logic [6:0] ROW1_OFFSET   = 7'h40;

    localparam logic [2:0] CTRL_DISPLAY = 3'b100;
    localparam logic [2:0] CTRL_CURSOR  = 3'b010;
    localparam logic [2:0] CTRL_BLINK   = 3'b001;
    localparam logic [1:0] ENTRY_LTR    = 2'b10;
    localparam logic [1:0] ENTRY_AUTO   = 2'b01;
    localparam logic [2:0] CTRL_AFTER_INIT  = 3'b100;
    localparam logic [1:0] ENTRY_AFTER_INIT = 2'b10;

    // timing in microseconds
    localparam logic [15:0] WAIT_POWER_UP  = 16'd50000;
    localparam logic [15:0] WAIT_NONE      = 16'd0;
    localparam logic [12:0] SETTLE_PLAIN   = 13'd100;
    localparam logic [12:0] SETTLE_INIT_SH = 13'd250;
    localparam logic [12:0] SETTLE_LONG    = 13'd2100;
    localparam logic [12:0] SETTLE_INIT_LG = 13'd4600;

    localparam logic [3:0] INIT_LAST_STEP = 4'd11;
    localparam logic [3:0] BYTE_LAST_STEP = 4'd1;

    // one queued job: either the whole power-up sequence or one byte
    typedef struct packed {
        logic       init;
        logic       rs;
        logic [7:0] data;
        logic       long_settle;
    } job_t;

    typedef struct packed {
        logic [3:0]  nibble;
        logic [15:0] wait_before;
        logic [12:0] wait_after;
    } init_xfer_t;

    function automatic init_xfer_t init_xfer(input logic [3:0] step);
        init_xfer_t x;
        x.wait_before = WAIT_NONE;
        x.wait_after  = SETTLE_PLAIN;
        x.nibble      = 4'h0;
        case (step)
            4'd0:
            begin
                x.nibble      = 4'h3;
                x.wait_before = WAIT_POWER_UP;
                x.wait_after  = SETTLE_INIT_LG;
            end
            4'd1:
            begin
                x.nibble     = 4'h3;
                x.wait_after = SETTLE_INIT_LG;
            end
            4'd2:
            begin
                x.nibble     = 4'h3;
                x.wait_after = SETTLE_INIT_SH;
            end
            4'd3:  x.nibble = 4'h2;
            // function set, two lines, 4-bit bus
            4'd4:  x.nibble = 4'h2;
            4'd5:  x.nibble = 4'h8;
            // display on, cursor and blink off
            4'd6:  x.nibble = 4'h0;
            4'd7:  x.nibble = 4'hC;
            // clear
            4'd8:  x.nibble = 4'h0;
            4'd9:
            begin
                x.nibble     = 4'h1;
                x.wait_after = SETTLE_LONG;
            end
            // entry mode, left to right
            4'd10: x.nibble = 4'h0;
            4'd11: x.nibble = 4'h6;
            default: x.nibble = 4'h0;
        endcase
        return x;
    endfunction

endpackage

// ===== src/lcd4_if.sv =====
// ---------------------------------------------------------------------------
// lcd4 channel interfaces
// Request, nibble transfer and register write channels, each valid/ready.
// ---------------------------------------------------------------------------
interface lcd4_req_if;
    logic       valid;
    logic       ready;
    logic [3:0] cmd;
    logic [7:0] value;
    logic [6:0] col;
    logic [7:0] row;
    logic [7:0] location;
    logic       flag_on;

    modport source (output valid, cmd, value, col, row, location, flag_on, input ready);
    modport sink   (input valid, cmd, value, col, row, location, flag_on, output ready);
endinterface

interface lcd4_xfer_if;
    logic        valid;
    logic        ready;
    logic        rs;
    logic [3:0]  nibble;
    logic [15:0] wait_before_us;
    logic [12:0] wait_after_us;
    logic        last;

    modport source (output valid, rs, nibble, wait_before_us, wait_after_us, last,
                    input ready);
    modport sink   (input valid, rs, nibble, wait_before_us, wait_after_us, last,
                    output ready);
endinterface

interface lcd4_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/lcd4_queue.sv =====
// ---------------------------------------------------------------------------
// lcd4_queue
// Small job queue between the request decoder and the nibble sequencer.
// ---------------------------------------------------------------------------
module lcd4_queue
    import lcd4_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output job_t head_job
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign head_job  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== src/lcd4_front.sv =====
// ---------------------------------------------------------------------------
// lcd4_front
// Request decoder: holds the geometry registers and the control and entry
// flags, turns each known request into one queued job; unused codes are dropped.
// ---------------------------------------------------------------------------
module lcd4_front
    import lcd4_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    lcd4_req_if.sink req,
    lcd4_cfg_if.sink cfg,
    input  logic queue_full,
    output logic push,
    output job_t push_job
);

    logic [5:0] columns_reg, columns_next;
    logic [2:0] line_count_reg, line_count_next;
    logic [2:0] ctrl_reg, ctrl_next;
    logic [1:0] entry_reg, entry_next;

    logic       accept;
    logic       known;
    logic [2:0] ctrl_bit;
    logic [1:0] entry_bit;
    logic [2:0] lines;
    logic [1:0] row_clamp;
    logic [6:0] row_offset;
    logic [6:0] addr;

    assign req.ready = !queue_full;
    assign cfg.ready = 1'b1;
    assign accept    = req.valid && req.ready;
    assign push      = accept && known;

    // cursor address: clamp row to 3, then to the line count less one
    always_comb
    begin
        lines     = (line_count_reg == 3'd0) ? 3'd1 : line_count_reg;
        row_clamp = (req.row > 8'd3) ? 2'd3 : req.row[1:0];
        if ({1'b0, row_clamp} >= lines)
        begin
            row_clamp = 2'(lines - 3'd1);
        end
        case (row_clamp)
            2'd0:    row_offset = 7'h00;
            2'd1:    row_offset = ROW1_OFFSET;
            2'd2:    row_offset = {1'b0, columns_reg};
            default: row_offset = ROW1_OFFSET + {1'b0, columns_reg};
        endcase
        addr = req.col + row_offset;
    end

    always_comb
    begin
        ctrl_next       = ctrl_reg;
        entry_next      = entry_reg;
        columns_next    = columns_reg;
        line_count_next = line_count_reg;
        known           = 1'b1;
        ctrl_bit        = CTRL_BLINK;
        entry_bit       = ENTRY_AUTO;
        push_job.init        = 1'b0;
        push_job.rs          = 1'b0;
        push_job.data        = req.value;
        push_job.long_settle = 1'b0;

        case (cmd_t'(req.cmd))
            CMD_DISPLAY:   ctrl_bit = CTRL_DISPLAY;
            CMD_CURSOR:    ctrl_bit = CTRL_CURSOR;
            default:       ctrl_bit = CTRL_BLINK;
        endcase
        entry_bit = (cmd_t'(req.cmd) == CMD_DIRECTION) ? ENTRY_LTR : ENTRY_AUTO;

        case (cmd_t'(req.cmd))
            CMD_INIT:
            begin
                push_job.init = 1'b1;
                ctrl_next     = CTRL_AFTER_INIT;
                entry_next    = ENTRY_AFTER_INIT;
            end
            CMD_DATA:       push_job.rs = 1'b1;
            CMD_RAW:        push_job.data = req.value;
            CMD_CLEAR:
            begin
                push_job.data        = OP_CLEAR;
                push_job.long_settle = 1'b1;
            end
            CMD_HOME:
            begin
                push_job.data        = OP_HOME;
                push_job.long_settle = 1'b1;
            end
            CMD_SET_CURSOR: push_job.data = OP_DDRAM_ADDR | {1'b0, addr};
            CMD_DISPLAY, CMD_CURSOR, CMD_BLINK:
            begin
                ctrl_next     = req.flag_on ? (ctrl_reg | ctrl_bit) : (ctrl_reg & ~ctrl_bit);
                push_job.data = OP_CONTROL | {5'd0, ctrl_next};
            end
            CMD_SCROLL:     push_job.data = req.flag_on ? OP_SHIFT_R : OP_SHIFT_L;
            CMD_DIRECTION, CMD_AUTOSCROLL:
            begin
                entry_next    = req.flag_on ? (entry_reg | entry_bit)
                                            : (entry_reg & ~entry_bit);
                push_job.data = OP_ENTRY | {6'd0, entry_next};
            end
            CMD_GLYPH_ADDR: push_job.data = OP_GLYPH_ADDR | {2'd0, req.location[2:0], 3'd0};
            default:        known = 1'b0;
        endcase

        if (!accept)
        begin
            ctrl_next  = ctrl_reg;
            entry_next = entry_reg;
        end

        if (cfg.valid)
        begin
            case (cfg_index_t'(cfg.index))
                CFG_COLUMNS:    columns_next    = cfg.data[5:0];
                CFG_LINE_COUNT: line_count_next = cfg.data[2:0];
                default:        columns_next    = columns_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg    <= COLUMNS_RESET;
            line_count_reg <= LINE_COUNT_RESET;
            ctrl_reg       <= '0;
            entry_reg      <= '0;
        end
        else
        begin
            columns_reg    <= columns_next;
            line_count_reg <= line_count_next;
            ctrl_reg       <= ctrl_next;
            entry_reg      <= entry_next;
        end
    end

endmodule

// ===== src/lcd4_back.sv =====
// ---------------------------------------------------------------------------
// lcd4_back
// Nibble sequencer: walks each queued job through its nibble transfers and
// holds them in an output register.
// ---------------------------------------------------------------------------
module lcd4_back
    import lcd4_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic job_valid,
    input  job_t head_job,
    output logic pop,
    lcd4_xfer_if.source xfer
);

    logic        busy_reg, busy_next;
    logic [3:0]  step_reg, step_next;
    job_t        job_reg;
    logic        out_valid_reg, out_valid_next;
    logic        rs_reg;
    logic [3:0]  nibble_reg;
    logic [15:0] before_reg;
    logic [12:0] after_reg;
    logic        last_reg;

    job_t        cur_job;
    logic [3:0]  cur_step;
    logic [3:0]  last_step;
    logic        have;
    logic        advance;
    logic        is_last;
    init_xfer_t  ix;
    logic [3:0]  nib_val;
    logic [15:0] before_val;
    logic [12:0] after_val;

    // a new job starts straight from the queue head, no bubble in between
    assign cur_job   = busy_reg ? job_reg : head_job;
    assign cur_step  = busy_reg ? step_reg : 4'd0;
    assign have      = busy_reg || job_valid;
    assign advance   = have && (!out_valid_reg || xfer.ready);
    assign pop       = advance && !busy_reg;
    assign last_step = cur_job.init ? INIT_LAST_STEP : BYTE_LAST_STEP;
    assign is_last   = (cur_step == last_step);

    always_comb
    begin
        ix = init_xfer(cur_step);
        if (cur_job.init)
        begin
            nib_val    = ix.nibble;
            before_val = ix.wait_before;
            after_val  = ix.wait_after;
        end
        else
        begin
            before_val = WAIT_NONE;
            if (cur_step == 4'd0)
            begin
                nib_val   = cur_job.data[7:4];
                after_val = SETTLE_PLAIN;
            end
            else
            begin
                nib_val   = cur_job.data[3:0];
                after_val = cur_job.long_settle ? SETTLE_LONG : SETTLE_PLAIN;
            end
        end
    end

    always_comb
    begin
        busy_next      = busy_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
            busy_next      = !is_last;
            step_next      = cur_step + 4'd1;
        end
        else if (xfer.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            job_reg    <= cur_job;
            rs_reg     <= cur_job.rs;
            nibble_reg <= nib_val;
            before_reg <= before_val;
            after_reg  <= after_val;
            last_reg   <= is_last;
        end
    end

    assign xfer.valid          = out_valid_reg;
    assign xfer.rs             = rs_reg;
    assign xfer.nibble         = nibble_reg;
    assign xfer.wait_before_us = before_reg;
    assign xfer.wait_after_us  = after_reg;
    assign xfer.last           = last_reg;

endmodule

// ===== src/char_lcd_4bit_command_sequencer_unit.sv =====
// ---------------------------------------------------------------------------
// char_lcd_4bit_command_sequencer_unit
// Turns character LCD requests into 4-bit nibble transfers with timing.
// ---------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  req      in   valid/ready    cmd, value, col, row, location, flag_on
//  xfer     out  valid/ready    rs, nibble, wait_before_us, wait_after_us, last
//  cfg      in   valid/ready    index, data (0 columns, 1 line_count)
//
//  while xfer is ready, one nibble transfer per cycle leaves the output
//  register; a byte request is 2 transfers and init 12, set by the step counter
//  requests enter at one per cycle while the job queue has room
//  output stalls fill the queue, then drop req.ready; cfg is always ready
//  reset: columns 16, line count 2, all flags clear, queue empty
// ---------------------------------------------------------------------------
module char_lcd_4bit_command_sequencer_unit
    import lcd4_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic clk,
    input  logic rst_n,
    lcd4_req_if.sink    req,
    lcd4_cfg_if.sink    cfg,
    lcd4_xfer_if.source xfer
);

    logic push;
    job_t push_job;
    logic full;
    logic pop;
    logic not_empty;
    job_t head_job;

    lcd4_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .cfg        (cfg),
        .queue_full (full),
        .push       (push),
        .push_job   (push_job)
    );

    lcd4_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .full      (full),
        .pop       (pop),
        .not_empty (not_empty),
        .head_job  (head_job)
    );

    lcd4_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (not_empty),
        .head_job  (head_job),
        .pop       (pop),
        .xfer      (xfer)
    );

endmodule

// ===== dv/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 4-bit character LCD command sequencer. A table
// of directed requests covers every request type and the corner cases, then
// random requests run under several column and line settings. Each accepted
// request is expanded by a local sequencer model into nibble transfers that
// the output monitor checks in order. Both channels idle at random, and one
// long output hold-off backs the request channel up.
// ---------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lcd4_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 9;
    localparam int IDLE_PCT     = 36;
    localparam int PHASES       = 5;
    localparam int PHASE_ITEMS  = 21;
    localparam int HOLD_CYCLES  = 200;
    localparam int SETTLE_GAP   = 24;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_PRINTS   = 40;

    localparam logic [3:0] CMD_UNUSED_LO    = 4'd13;
    localparam logic [3:0] CMD_UNUSED_HI    = 4'd15;
    localparam logic [3:0] CFG_UNMAPPED_TOP = 4'd15;

    localparam logic       RS_CMD          = 1'b0;
    localparam logic       RS_DATA         = 1'b1;
    localparam logic [3:0] WAKE_NIBBLE     = 4'h3;
    localparam logic [3:0] BUS_4BIT_NIBBLE = 4'h2;
    // function set: 4-bit bus, two lines
    localparam logic [7:0] FUNCTION_SET    = 8'h28;

    typedef struct packed {
        logic [3:0] cmd;
        logic [7:0] value;
        logic [6:0] col;
        logic [7:0] row;
        logic [7:0] location;
        logic       flag_on;
    } lcd_req_t;

    // known rows carry the byte that is expected back
    typedef struct packed {
        lcd_req_t    item;
        logic        known;
        logic        rs;
        logic [7:0]  code;
        logic [12:0] settle;
    } req_row_t;

    typedef struct packed {
        logic        rs;
        logic [3:0]  nibble;
        logic [15:0] wait_before;
        logic [12:0] wait_after;
        logic        last;
    } xfer_t;

    logic clk = 1'b0;
    logic rst_n;

    lcd4_req_if  req_bus ();
    lcd4_cfg_if  cfg_bus ();
    lcd4_xfer_if xfer_bus ();

    char_lcd_4bit_command_sequencer_unit u_top
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .cfg   (cfg_bus),
        .xfer  (xfer_bus)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // sequencer model state
    logic [5:0] columns_q;
    logic [2:0] lines_q;
    logic [2:0] ctrl_flags;
    logic [1:0] entry_flags;

    xfer_t planned[$];
    xfer_t pending_xfers[$];
    int    mismatches = 0;
    int    hold_asks = 0;
    logic  steady = 1'b0;

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    function automatic void push_nibble(input logic rs, input logic [3:0] nib,
                                        input logic [15:0] pre_wait,
                                        input logic [12:0] after, input logic fin);
        xfer_t x;
        x.rs          = rs;
        x.nibble      = nib;
        x.wait_before = pre_wait;
        x.wait_after  = after;
        x.last        = fin;
        planned.push_back(x);
    endfunction

    // high nibble first, only the low nibble may get the long settle
    function automatic void push_byte(input logic rs, input logic [7:0] code,
                                      input logic [12:0] settle_low, input logic fin);
        push_nibble(rs, code[7:4], WAIT_NONE, SETTLE_PLAIN, 1'b0);
        push_nibble(rs, code[3:0], WAIT_NONE, settle_low, fin);
    endfunction

    function automatic void plan_transfers(input lcd_req_t q);
        int         lines;
        int         line;
        logic [6:0] offset;
        logic [6:0] addr;
        logic [2:0] ctl_bit;
        logic [1:0] ent_bit;
        planned.delete();
        case (q.cmd)
            CMD_INIT:
            begin
                push_nibble(RS_CMD, WAKE_NIBBLE, WAIT_POWER_UP, SETTLE_INIT_LG, 1'b0);
                push_nibble(RS_CMD, WAKE_NIBBLE, WAIT_NONE, SETTLE_INIT_LG, 1'b0);
                push_nibble(RS_CMD, WAKE_NIBBLE, WAIT_NONE, SETTLE_INIT_SH, 1'b0);
                push_nibble(RS_CMD, BUS_4BIT_NIBBLE, WAIT_NONE, SETTLE_PLAIN, 1'b0);
                push_byte(RS_CMD, FUNCTION_SET, SETTLE_PLAIN, 1'b0);
                ctrl_flags = CTRL_AFTER_INIT;
                push_byte(RS_CMD, OP_CONTROL | {5'b0, ctrl_flags}, SETTLE_PLAIN, 1'b0);
                push_byte(RS_CMD, OP_CLEAR, SETTLE_LONG, 1'b0);
                entry_flags = ENTRY_AFTER_INIT;
                push_byte(RS_CMD, OP_ENTRY | {6'b0, entry_flags}, SETTLE_PLAIN, 1'b1);
            end
            CMD_DATA:  push_byte(RS_DATA, q.value, SETTLE_PLAIN, 1'b1);
            CMD_RAW:   push_byte(RS_CMD, q.value, SETTLE_PLAIN, 1'b1);
            CMD_CLEAR: push_byte(RS_CMD, OP_CLEAR, SETTLE_LONG, 1'b1);
            CMD_HOME:  push_byte(RS_CMD, OP_HOME, SETTLE_LONG, 1'b1);
            CMD_SET_CURSOR:
            begin
                lines = (lines_q == 3'd0) ? 1 : int'(lines_q);
                line  = (q.row > 8'd3) ? 3 : int'(q.row);
                if (line >= lines)
                    line = lines - 1;
                case (line)
                    0:       offset = 7'h00;
                    1:       offset = ROW1_OFFSET;
                    2:       offset = {1'b0, columns_q};
                    default: offset = ROW1_OFFSET + {1'b0, columns_q};
                endcase
                addr = q.col + offset;
                push_byte(RS_CMD, OP_DDRAM_ADDR | {1'b0, addr}, SETTLE_PLAIN, 1'b1);
            end
            CMD_DISPLAY, CMD_CURSOR, CMD_BLINK:
            begin
                if (q.cmd == CMD_DISPLAY)
                    ctl_bit = CTRL_DISPLAY;
                else if (q.cmd == CMD_CURSOR)
                    ctl_bit = CTRL_CURSOR;
                else
                    ctl_bit = CTRL_BLINK;
                ctrl_flags = q.flag_on ? (ctrl_flags | ctl_bit) : (ctrl_flags & ~ctl_bit);
                push_byte(RS_CMD, OP_CONTROL | {5'b0, ctrl_flags}, SETTLE_PLAIN, 1'b1);
            end
            CMD_SCROLL:
                push_byte(RS_CMD, q.flag_on ? OP_SHIFT_R : OP_SHIFT_L, SETTLE_PLAIN, 1'b1);
            CMD_DIRECTION, CMD_AUTOSCROLL:
            begin
                ent_bit = (q.cmd == CMD_DIRECTION) ? ENTRY_LTR : ENTRY_AUTO;
                entry_flags = q.flag_on ? (entry_flags | ent_bit)
                                        : (entry_flags & ~ent_bit);
                push_byte(RS_CMD, OP_ENTRY | {6'b0, entry_flags}, SETTLE_PLAIN, 1'b1);
            end
            CMD_GLYPH_ADDR:
                push_byte(RS_CMD, OP_GLYPH_ADDR | {2'b0, q.location[2:0], 3'b0},
                          SETTLE_PLAIN, 1'b1);
            default: ;  // unused codes produce nothing
        endcase
    endfunction

    function automatic req_row_t tab_row(input logic [3:0] cmd, input logic [7:0] value,
                                         input logic [6:0] col, input logic [7:0] row,
                                         input logic [7:0] loc, input logic on,
                                         input logic known, input logic rs,
                                         input logic [7:0] code, input logic [12:0] settle);
        req_row_t r;
        r.item.cmd      = cmd;
        r.item.value    = value;
        r.item.col      = col;
        r.item.row      = row;
        r.item.location = loc;
        r.item.flag_on  = on;
        r.known         = known;
        r.rs            = rs;
        r.code          = code;
        r.settle        = settle;
        return r;
    endfunction

    function automatic req_row_t random_row(input logic [3:0] cmd);
        logic [7:0] row_v;
        row_v = $urandom_range(0, 1) ? 8'($urandom_range(0, 4)) : 8'($urandom);
        return tab_row(cmd, 8'($urandom), 7'($urandom), row_v, 8'($urandom),
                       1'($urandom), 1'b0, RS_CMD, 8'h00, SETTLE_PLAIN);
    endfunction

    function automatic logic [3:0] random_cmd();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 6)
            return CMD_INIT;
        else if (pick < 11)
            return 4'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
        return 4'($urandom_range(CMD_DATA, CMD_GLYPH_ADDR));
    endfunction

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_request(input req_row_t r);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            req_bus.valid <= 1'b0;
            @(negedge clk);
        end
        req_bus.valid    <= 1'b1;
        req_bus.cmd      <= r.item.cmd;
        req_bus.value    <= r.item.value;
        req_bus.col      <= r.item.col;
        req_bus.row      <= r.item.row;
        req_bus.location <= r.item.location;
        req_bus.flag_on  <= r.item.flag_on;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        plan_transfers(r.item);
        if (r.known)
        begin
            planned.delete();
            push_byte(r.rs, r.code, r.settle, 1'b1);
        end
        foreach (planned[i])
            pending_xfers.push_back(planned[i]);
        @(negedge clk);
    endtask

    task automatic drain_block();
        req_bus.valid <= 1'b0;
        while (pending_xfers.size() != 0)
            @(posedge clk);
        // an unused code may still be passing through
        repeat (SETTLE_GAP) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_register(input logic [3:0] idx, input logic [7:0] data);
        drain_block();
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        case (idx)
            CFG_COLUMNS:    columns_q = data[5:0];
            CFG_LINE_COUNT: lines_q   = data[2:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // output side: random stalls, plus one long hold-off on request
    initial
    begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        xfer_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_seen != hold_asks)
            begin
                hold_seen = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                xfer_bus.ready <= 1'b0;
            end
            else
                xfer_bus.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // transfer checker
    initial
    begin
        xfer_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && xfer_bus.valid && xfer_bus.ready)
            begin
                if (pending_xfers.size() == 0)
                    report_mismatch($sformatf("transfer rs %0d nibble %h with nothing pending",
                                              xfer_bus.rs, xfer_bus.nibble));
                else
                begin
                    want = pending_xfers.pop_front();
                    if (xfer_bus.rs !== want.rs || xfer_bus.nibble !== want.nibble ||
                        xfer_bus.wait_before_us !== want.wait_before ||
                        xfer_bus.wait_after_us !== want.wait_after ||
                        xfer_bus.last !== want.last)
                        report_mismatch($sformatf(
                            "got rs %0d nib %h pre %0d post %0d last %0d, want %0d %h %0d %0d %0d",
                            xfer_bus.rs, xfer_bus.nibble, xfer_bus.wait_before_us,
                            xfer_bus.wait_after_us, xfer_bus.last, want.rs, want.nibble,
                            want.wait_before, want.wait_after, want.last));
                end
            end
        end
    end

    initial
    begin
        #3_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        req_row_t table_rows[$];
        int       sent;
        rst_n            = 1'b0;
        req_bus.valid    = 1'b0;
        req_bus.cmd      = CMD_INIT;
        req_bus.value    = 8'h00;
        req_bus.col      = 7'h00;
        req_bus.row      = 8'h00;
        req_bus.location = 8'h00;
        req_bus.flag_on  = 1'b0;
        cfg_bus.valid    = 1'b0;
        cfg_bus.index    = CFG_COLUMNS;
        cfg_bus.data     = 8'h00;
        columns_q        = COLUMNS_RESET;
        lines_q          = LINE_COUNT_RESET;
        ctrl_flags       = 3'b000;
        entry_flags      = 2'b00;

        // corner rows; registers still hold their reset values here
        table_rows.push_back(tab_row(CMD_DATA, 8'h00, 0, 0, 0, 0,
                                     1, RS_DATA, 8'h00, SETTLE_PLAIN));
        table_rows.push_back(tab_row(CMD_DATA, 8'hFF, 0, 0, 0, 1,
                                     1, RS_DATA, 8'hFF, SETTLE_PLAIN));
        table_rows.push_back(tab_row(CMD_DISPLAY, 8'h00, 0, 0, 0, 1,
                                     1, RS_CMD, OP_CONTROL | 8'(CTRL_DISPLAY), SETTLE_PLAIN));
        table_rows.push_back(tab_row(CMD_CLEAR, 8'h00, 0, 0, 0, 0,
                                     1, RS_CMD, OP_CLEAR, SETTLE_LONG));
        table_rows.push_back(tab_row(CMD_HOME, 8'h00, 0, 0, 0, 0,
                                     1, RS_CMD, OP_HOME, SETTLE_LONG));
        table_rows.push_back(tab_row(CMD_SET_CURSOR, 8'h00, 0, 0, 0, 0,
                                     1, RS_CMD, OP_DDRAM_ADDR, SETTLE_PLAIN));
        table_rows.push_back(tab_row(CMD_INIT, 8'h00, 0, 0, 0, 0, 0, RS_CMD, 0, 0));
        // raw clear byte keeps the short settle
        table_rows.push_back(tab_row(CMD_RAW, OP_CLEAR, 0, 0, 0, 0,
                                     1, RS_CMD, OP_CLEAR, SETTLE_PLAIN));
        table_rows.push_back(tab_row(CMD_RAW, 8'hA5, 0, 0, 0, 1,
                                     1, RS_CMD, 8'hA5, SETTLE_PLAIN));
        table_rows.push_back(tab_row(CMD_SET_CURSOR, 8'h00, 7'h7F, 8'hFF, 0, 0,
                                     0, RS_CMD, 0, 0));
        table_rows.push_back(tab_row(CMD_SET_CURSOR, 8'h00, 7'h64, 8'h01, 0, 1,
                                     0, RS_CMD, 0, 0));
        table_rows.push_back(tab_row(CMD_CURSOR, 8'h00, 0, 0, 0, 1, 0, RS_CMD, 0, 0));
        table_rows.push_back(tab_row(CMD_BLINK, 8'h00, 0, 0, 0, 1, 0, RS_CMD, 0, 0));
        table_rows.push_back(tab_row(CMD_DISPLAY, 8'h00, 0, 0, 0, 0, 0, RS_CMD, 0, 0));
        table_rows.push_back(tab_row(CMD_CURSOR, 8'h00, 0, 0, 0, 0, 0, RS_CMD, 0, 0));
        table_rows.push_back(tab_row(CMD_BLINK, 8'h00, 0, 0, 0, 0, 0, RS_CMD, 0, 0));
        table_rows.push_back(tab_row(CMD_SCROLL, 8'h00, 0, 0, 0, 1,
                                     1, RS_CMD, OP_SHIFT_R, SETTLE_PLAIN));
        table_rows.push_back(tab_row(CMD_SCROLL, 8'h00, 0, 0, 0, 0,
                                     1, RS_CMD, OP_SHIFT_L, SETTLE_PLAIN));
        table_rows.push_back(tab_row(CMD_DIRECTION, 8'h00, 0, 0, 0, 1, 0, RS_CMD, 0, 0));
        table_rows.push_back(tab_row(CMD_AUTOSCROLL, 8'h00, 0, 0, 0, 1, 0, RS_CMD, 0, 0));
        table_rows.push_back(tab_row(CMD_DIRECTION, 8'h00, 0, 0, 0, 0, 0, RS_CMD, 0, 0));
        table_rows.push_back(tab_row(CMD_AUTOSCROLL, 8'h00, 0, 0, 0, 0, 0, RS_CMD, 0, 0));
        table_rows.push_back(tab_row(CMD_GLYPH_ADDR, 8'h00, 0, 0, 8'hFF, 0, 0, RS_CMD, 0, 0));
        table_rows.push_back(tab_row(CMD_GLYPH_ADDR, 8'h00, 0, 0, 8'h00, 1,
                                     1, RS_CMD, OP_GLYPH_ADDR, SETTLE_PLAIN));
        table_rows.push_back(tab_row(CMD_UNUSED_HI, 8'hFF, 7'h7F, 8'hFF, 8'hFF, 1,
                                     0, RS_CMD, 0, 0));

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (table_rows[i])
            send_request(table_rows[i]);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    write_register(CFG_COLUMNS, 8'd40);
                    write_register(CFG_LINE_COUNT, 8'd4);
                end
                1:
                begin
                    write_register(CFG_COLUMNS, 8'd1);
                    write_register(CFG_LINE_COUNT, 8'd1);
                    hold_asks++;
                end
                2:
                begin
                    // out-of-range values, zero lines acts as one
                    write_register(CFG_COLUMNS, 8'hFF);
                    write_register(CFG_LINE_COUNT, 8'h00);
                    write_register(CFG_UNMAPPED_TOP, 8'hA5);
                end
                3:
                begin
                    write_register(CFG_COLUMNS, 8'($urandom));
                    write_register(CFG_LINE_COUNT, 8'($urandom));
                    write_register(4'($urandom_range(CFG_LINE_COUNT + 1, CFG_UNMAPPED_TOP)),
                                   8'($urandom));
                end
                default:
                begin
                    write_register(CFG_COLUMNS, 8'd20);
                    write_register(CFG_LINE_COUNT, 8'd3);
                    steady = 1'b1;
                end
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 99) < 8)
                begin
                    // glyph definition: address then eight pattern rows
                    send_request(random_row(CMD_GLYPH_ADDR));
                    repeat (8) send_request(random_row(CMD_DATA));
                    sent += 9;
                end
                else
                begin
                    send_request(random_row(random_cmd()));
                    sent++;
                end
            end
        end

        drain_block();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
